// ----- design/ppm_hp_pkg.sv -----
// shared constants and types for the ppm p6 header parser
// status codes, character codes, field width and the result record
// no dependencies
package ppm_hp_pkg;

    // width of one decimal number field
    localparam int FIELD_BITS = 16;
    localparam int OUT_BITS   = 16;

    // character codes
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_P     = 8'd80;
    localparam logic [7:0] CH_SIX   = 8'd54;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [3:0] RADIX    = 4'd10;

    // result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_MAGIC = 3'd1;
    localparam logic [2:0] STAT_BAD_NUM   = 3'd2;
    localparam logic [2:0] STAT_NO_WS     = 3'd3;
    localparam logic [2:0] STAT_EARLY_END = 3'd4;

    typedef struct packed {
        logic [2:0]          status;
        logic [OUT_BITS-1:0] width;
        logic [OUT_BITS-1:0] height;
        logic [OUT_BITS-1:0] max_color;
        logic [OUT_BITS-1:0] data_offset;
    } result_t;

endpackage

// ----- design/ppm_p6_header_parser_unit.sv -----
// ppm p6 header parser: top level with input and result registers
// uses ppm_hp_parse for the per-byte state machine
// depends on ppm_hp_pkg
//
// usage
// - byte channel: byte_valid, byte_stall, byte_value, last_byte. one buffer
//   byte per beat; last_byte marks the final byte and restarts the parser.
// - result channel: result_valid, result_stall and the five result fields.
//   at most one result per buffer: status, width, height, max_color and
//   data_offset, given as soon as the outcome is known (or at the last byte).
// - registers: a taken byte is held in the input register and parsed from there;
//   its result is held in the result register and visible from there.
// - throughput: one byte per cycle unless stalled, set by the single state update
//   per byte (one times-ten add and a compare) between input and result registers.
// - when the receiver stalls with a result waiting, the parser holds the
//   byte in its input register and raises byte_stall until the result is taken.
// - reset clears the parse state and the input and result valid flags;
//   the block takes bytes in the first cycle after reset.
module ppm_p6_header_parser_unit
    import ppm_hp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  logic [7:0]          byte_value,
    input  logic                last_byte,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [2:0]          status,
    output logic [OUT_BITS-1:0] width,
    output logic [OUT_BITS-1:0] height,
    output logic [OUT_BITS-1:0] max_color,
    output logic [OUT_BITS-1:0] data_offset
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       res_valid_reg, res_valid_next;
    result_t    res_reg;
    logic       accept;
    logic       advance;
    logic       emit;
    result_t    result;

    // handshake: a held byte waits while a result is blocked
    assign advance    = in_valid_reg && !(res_valid_reg && result_stall);
    assign byte_stall = in_valid_reg && res_valid_reg && result_stall;
    assign accept     = byte_valid && !byte_stall;

    ppm_hp_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (advance),
        .byte_in (byte_reg),
        .last_in (last_reg),
        .emit    (emit),
        .result  (result)
    );

    // next valid flags
    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance && emit)
            res_valid_next = 1'b1;
        else if (!result_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_value;
            last_reg <= last_byte;
        end
        if (advance && emit)
            res_reg <= result;
    end

    // result ports
    assign result_valid = res_valid_reg;
    assign status       = res_reg.status;
    assign width        = res_reg.width;
    assign height       = res_reg.height;
    assign max_color    = res_reg.max_color;
    assign data_offset  = res_reg.data_offset;

endmodule

// ----- design/ppm_hp_parse.sv -----
// header parse state machine: one byte per beat, at most one result per beat
// holds the parse state and produces the result for the byte it is given
// depends on ppm_hp_pkg
module ppm_hp_parse
    import ppm_hp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,
    input  logic [7:0] byte_in,
    input  logic       last_in,
    output logic       emit,
    output result_t    result
);

    typedef enum logic [3:0] {
        PH_PRE,
        PH_GOT_P,
        PH_GOT_6,
        PH_SEP_W,
        PH_NUM_W,
        PH_SEP_H,
        PH_NUM_H,
        PH_SEP_M,
        PH_NUM_M,
        PH_SEP_D
    } phase_t;

    localparam logic [OUT_BITS-1:0] POS_MAX = '1;

    phase_t                phase_reg, phase_next;
    logic                  in_comment_reg, in_comment_next;
    logic                  seen_ws_reg, seen_ws_next;
    logic [FIELD_BITS-1:0] acc_reg, acc_next;
    logic [FIELD_BITS-1:0] saved_w_reg, saved_w_next;
    logic [FIELD_BITS-1:0] saved_h_reg, saved_h_next;
    logic [OUT_BITS-1:0]   pos_reg, pos_next;
    logic                  reported_reg, reported_next;

    logic                  is_ws;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [FIELD_BITS+3:0] acc_sum;
    logic                  acc_ovf;
    logic [OUT_BITS-1:0]   pos_inc;
    logic                  emit_now;
    logic                  emit_end;
    logic [2:0]            st;

    // byte classes and the times-ten accumulate
    assign is_ws    = (byte_in == CH_SPACE) || ((byte_in >= CH_TAB) && (byte_in <= CH_CR));
    assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign digit    = 4'(byte_in - CH_ZERO);
    assign acc_sum  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + (FIELD_BITS+4)'(digit);
    assign acc_ovf  = |acc_sum[FIELD_BITS+3:FIELD_BITS];
    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    // next state and result for the current byte
    always_comb
    begin
        phase_next      = phase_reg;
        in_comment_next = in_comment_reg;
        seen_ws_next    = seen_ws_reg;
        acc_next        = acc_reg;
        saved_w_next    = saved_w_reg;
        saved_h_next    = saved_h_reg;
        emit_now        = 1'b0;
        emit_end        = 1'b0;
        st              = STAT_OK;
        if (go && !reported_reg)
        begin
            case (phase_reg)
                PH_PRE:
                begin
                    if (in_comment_reg)
                    begin
                        if (byte_in == CH_NL)
                            in_comment_next = 1'b0;
                    end
                    else if (byte_in == CH_HASH)
                        in_comment_next = 1'b1;
                    else if (!is_ws)
                    begin
                        if (byte_in != CH_P)
                        begin
                            emit_now = 1'b1;
                            st       = STAT_BAD_MAGIC;
                        end
                        else
                            phase_next = PH_GOT_P;
                    end
                end
                PH_GOT_P:
                begin
                    if (byte_in != CH_SIX)
                    begin
                        emit_now = 1'b1;
                        st       = STAT_BAD_MAGIC;
                    end
                    else
                        phase_next = PH_GOT_6;
                end
                PH_GOT_6:
                begin
                    if (!is_ws)
                    begin
                        emit_now = 1'b1;
                        st       = STAT_BAD_MAGIC;
                    end
                    else
                        phase_next = PH_SEP_W;
                end
                PH_NUM_W, PH_NUM_H, PH_NUM_M:
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_sum[FIELD_BITS-1:0];
                        if (acc_ovf)
                        begin
                            emit_now = 1'b1;
                            st       = STAT_BAD_NUM;
                        end
                    end
                    else
                    begin
                        // number ends: close the field, then treat byte as separator
                        if (phase_reg == PH_NUM_W)
                        begin
                            saved_w_next = acc_reg;
                            phase_next   = PH_SEP_H;
                        end
                        else if (phase_reg == PH_NUM_H)
                        begin
                            saved_h_next = acc_reg;
                            phase_next   = PH_SEP_M;
                        end
                        else
                        begin
                            phase_next   = PH_SEP_D;
                            seen_ws_next = 1'b0;
                        end
                        if (byte_in == CH_HASH)
                            in_comment_next = 1'b1;
                        else if (is_ws)
                        begin
                            if (phase_reg == PH_NUM_M)
                                seen_ws_next = 1'b1;
                        end
                        else
                        begin
                            emit_now = 1'b1;
                            st       = (phase_reg == PH_NUM_M) ? STAT_NO_WS : STAT_BAD_NUM;
                        end
                    end
                end
                PH_SEP_W, PH_SEP_H, PH_SEP_M, PH_SEP_D:
                begin
                    if (in_comment_reg)
                    begin
                        if (byte_in == CH_NL)
                            in_comment_next = 1'b0;
                    end
                    else if (byte_in == CH_HASH)
                        in_comment_next = 1'b1;
                    else if (is_ws)
                    begin
                        if (phase_reg == PH_SEP_D)
                            seen_ws_next = 1'b1;
                    end
                    else if (phase_reg == PH_SEP_D)
                    begin
                        emit_now = 1'b1;
                        st       = seen_ws_reg ? STAT_OK : STAT_NO_WS;
                    end
                    else if (is_digit)
                    begin
                        acc_next = FIELD_BITS'(digit);
                        case (phase_reg)
                            PH_SEP_W: phase_next = PH_NUM_W;
                            PH_SEP_H: phase_next = PH_NUM_H;
                            default:  phase_next = PH_NUM_M;
                        endcase
                    end
                    else
                    begin
                        emit_now = 1'b1;
                        st       = STAT_BAD_NUM;
                    end
                end
                default:
                    phase_next = PH_PRE;
            endcase

            // buffer ends without an earlier outcome
            if (last_in && !emit_now)
            begin
                emit_end = 1'b1;
                if (phase_next == PH_SEP_D)
                    st = seen_ws_next ? STAT_OK : STAT_NO_WS;
                else
                    st = STAT_EARLY_END;
            end
        end
    end

    // result record
    always_comb
    begin
        emit             = emit_now || emit_end;
        result.status    = st;
        result.width     = OUT_BITS'(saved_w_next);
        result.height    = OUT_BITS'(saved_h_next);
        result.max_color = (phase_next == PH_SEP_D) ? OUT_BITS'(acc_next) : '0;
        if (st != STAT_OK)
            result.data_offset = '0;
        else if (emit_end)
            result.data_offset = pos_inc;
        else
            result.data_offset = pos_reg;
    end

    // position and report flag
    always_comb
    begin
        pos_next      = go ? pos_inc : pos_reg;
        reported_next = reported_reg || emit;
    end

    // state registers; the last byte of a buffer restarts the parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PRE;
            in_comment_reg <= 1'b0;
            seen_ws_reg    <= 1'b0;
            acc_reg        <= '0;
            saved_w_reg    <= '0;
            saved_h_reg    <= '0;
            pos_reg        <= '0;
            reported_reg   <= 1'b0;
        end
        else if (go && last_in)
        begin
            phase_reg      <= PH_PRE;
            in_comment_reg <= 1'b0;
            seen_ws_reg    <= 1'b0;
            acc_reg        <= '0;
            saved_w_reg    <= '0;
            saved_h_reg    <= '0;
            pos_reg        <= '0;
            reported_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            in_comment_reg <= in_comment_next;
            seen_ws_reg    <= seen_ws_next;
            acc_reg        <= acc_next;
            saved_w_reg    <= saved_w_next;
            saved_h_reg    <= saved_h_next;
            pos_reg        <= pos_next;
            reported_reg   <= reported_next;
        end
    end

endmodule
